@@ sv/tdst_pkg.sv @@
// Shared constants, types and helpers of the timed delay slot table.
// Depends on nothing; used by tdst_mod, timed_delay_slot_table and the testbench.
package tdst_pkg;

    // table geometry
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int LIVE_W     = 9;
    localparam int OCC_W      = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

    // limits and generator constants
    localparam int MAX_DATAGRAM    = 1500;
    localparam int LATENCY_CEILING = 2000;
    localparam logic [31:0] SEED_DEFAULT = 32'h5eed_1234;
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    // field widths
    localparam int CFG_W      = 11;
    localparam int RAND_W     = 32;
    localparam int SPAN_W     = CFG_W + 1;
    localparam int DELAY_W    = SPAN_W + 1;
    localparam int TIME_W     = 48;
    localparam int DUE_W      = TIME_W + 1;
    localparam int TAG_W      = 16;
    localparam int LEN_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int CAP_W      = 16;
    localparam int COUNT_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

    // request codes
    localparam logic REQ_HOLD = 1'b0;
    localparam logic REQ_POLL = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_HELD      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_REJECTED  = 3'd2,
        STAT_DELIVERED = 3'd3,
        STAT_NOTHING   = 3'd4,
        STAT_DROPPED   = 3'd5
    } status_t;

    // datagram descriptor as kept in the slot memory
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } desc_t;

    // one xorshift step
    function automatic logic [RAND_W-1:0] xorshift_step(input logic [RAND_W-1:0] x);
        logic [RAND_W-1:0] a;
        logic [RAND_W-1:0] b;
        a = x ^ (x << XS_A);
        b = a ^ (a >> XS_B);
        return b ^ (b << XS_C);
    endfunction

endpackage

@@ sv/tdst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/tdst_mod.sv @@
// Iterative remainder unit: random word modulo the jitter span, one bit a cycle.
// Depends on tdst_pkg.
module tdst_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tdst_pkg::RAND_W-1:0]   dividend,
    input  logic [tdst_pkg::SPAN_W-1:0]   divisor,
    output logic                          done,
    output logic [tdst_pkg::SPAN_W-1:0]   rem
);

    localparam int STEP_W = $clog2(tdst_pkg::RAND_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [tdst_pkg::RAND_W-1:0]   quo_reg;
    logic [tdst_pkg::SPAN_W-1:0]   div_reg;
    logic [tdst_pkg::SPAN_W-1:0]   rem_reg;
    logic [tdst_pkg::SPAN_W:0]     trial;
    logic [tdst_pkg::SPAN_W-1:0]   rem_next;

    // restoring remainder step
    always_comb
    begin
        trial = {rem_reg, quo_reg[tdst_pkg::RAND_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = tdst_pkg::SPAN_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[tdst_pkg::SPAN_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(tdst_pkg::RAND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ sv/timed_delay_slot_table.sv @@
// Top level of the timed delay slot table: control, slot valid bits, counters.
// Depends on tdst_pkg, tdst_ram and tdst_mod.
//
//   channel   direction   handshake               payload
//   request   in          in_valid / in_stall     req_type, now_ms, buffer_tag, length,
//                                                 src_addr, src_port, capacity
//   result    out         out_valid / out_stall   status, out_tag, out_length, out_src_addr,
//                                                 out_src_port, live_count, peak_count,
//                                                 overflow_count
//   config    in          cfg_we                  cfg_index, cfg_data
//
// A poll scans every slot, the due-time memory read one slot a cycle, and then reads the
// descriptor of the slot that comes due, if any. A hold runs the free-slot search, plus
// the bit-serial remainder with jitter. Rejected, full and zero-capacity requests go
// straight to the result. One request is worked at a time; the output register lets the
// next one be accepted while a result still waits. Reset clears the valid flops at once,
// no clearing pass.
module timed_delay_slot_table (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [tdst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdst_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [tdst_pkg::TIME_W-1:0]        now_ms,
    input  logic [tdst_pkg::TAG_W-1:0]         buffer_tag,
    input  logic [tdst_pkg::LEN_W-1:0]         length,
    input  logic [tdst_pkg::ADDR_W-1:0]        src_addr,
    input  logic [tdst_pkg::PORT_W-1:0]        src_port,
    input  logic [tdst_pkg::CAP_W-1:0]         capacity,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tdst_pkg::STATUS_W-1:0]      status,
    output logic [tdst_pkg::TAG_W-1:0]         out_tag,
    output logic [tdst_pkg::LEN_W-1:0]         out_length,
    output logic [tdst_pkg::ADDR_W-1:0]        out_src_addr,
    output logic [tdst_pkg::PORT_W-1:0]        out_src_port,
    output logic [tdst_pkg::LIVE_W-1:0]        live_count,
    output logic [tdst_pkg::LIVE_W-1:0]        peak_count,
    output logic [tdst_pkg::COUNT_W-1:0]       overflow_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOLD_SCAN,
        S_HOLD_MOD,
        S_HOLD_WRITE,
        S_POLL_SCAN,
        S_POLL_LAST,
        S_POLL_READ,
        S_FINISH
    } state_t;

    state_t                            state_reg;

    // configuration and generator
    logic [tdst_pkg::CFG_W-1:0]        latency_reg;
    logic [tdst_pkg::CFG_W-1:0]        jitter_reg;
    logic [tdst_pkg::RAND_W-1:0]       rng_reg;

    // request held during work
    logic [tdst_pkg::TIME_W-1:0]       req_now_reg;
    tdst_pkg::desc_t                   req_desc_reg;
    logic [tdst_pkg::CAP_W-1:0]        req_cap_reg;

    // slot occupancy
    logic [tdst_pkg::SLOT_COUNT-1:0]   slot_valid_reg;
    logic [tdst_pkg::SLOT_W-1:0]       scan_idx_reg;
    logic [tdst_pkg::SLOT_W-1:0]       free_idx_reg;
    logic [tdst_pkg::DELAY_W-1:0]      delay_reg;

    // poll search
    logic                              cmp_pend_reg;
    logic                              cand_valid_reg;
    logic [tdst_pkg::SLOT_W-1:0]       cand_idx_reg;
    logic                              best_found_reg;
    logic [tdst_pkg::SLOT_W-1:0]       best_idx_reg;
    logic [tdst_pkg::DUE_W-1:0]        best_due_reg;

    // counters
    logic [tdst_pkg::OCC_W-1:0]        occ_reg;
    logic [tdst_pkg::OCC_W-1:0]        peak_reg;
    logic [tdst_pkg::COUNT_W-1:0]      refused_reg;

    // result and output register
    tdst_pkg::status_t                 res_status_reg;
    tdst_pkg::desc_t                   res_desc_reg;
    logic                              out_valid_reg;
    tdst_pkg::status_t                 out_status_reg;
    tdst_pkg::desc_t                   out_desc_reg;
    logic [tdst_pkg::LIVE_W-1:0]       out_live_reg;
    logic [tdst_pkg::LIVE_W-1:0]       out_peak_reg;
    logic [tdst_pkg::COUNT_W-1:0]      out_refused_reg;

    // combinational
    logic                              in_xfer;
    logic                              out_xfer;
    logic [tdst_pkg::CFG_W-1:0]        jit_eff;
    logic                              hold_ok;
    logic                              table_full;
    logic [tdst_pkg::RAND_W-1:0]       rng_next;
    logic                              scan_free;
    logic                              mod_start;
    logic                              mod_done;
    logic [tdst_pkg::SPAN_W-1:0]       mod_rem;
    logic [tdst_pkg::SPAN_W-1:0]       span;
    logic [tdst_pkg::DUE_W-1:0]        due_wdata;
    logic [tdst_pkg::DUE_W-1:0]        due_rdata;
    tdst_pkg::desc_t                   desc_rdata;
    logic                              slot_we;
    logic                              cand_hit;
    logic                              best_found_next;
    logic [tdst_pkg::SLOT_W-1:0]       best_idx_next;
    logic [tdst_pkg::OCC_W-1:0]        occ_inc;
    logic                              res_is_slot;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // hold checks and jitter clamp
    assign jit_eff    = (jitter_reg > latency_reg) ? latency_reg : jitter_reg;
    assign hold_ok    = (latency_reg != '0)
                     && (latency_reg <= tdst_pkg::CFG_W'(tdst_pkg::LATENCY_CEILING))
                     && (length != '0)
                     && (length <= tdst_pkg::LEN_W'(tdst_pkg::MAX_DATAGRAM));
    assign table_full = (occ_reg == tdst_pkg::OCC_W'(tdst_pkg::SLOT_COUNT));
    assign rng_next   = tdst_pkg::xorshift_step(rng_reg);
    assign span       = {jit_eff, 1'b1};
    assign occ_inc    = occ_reg + 1'b1;

    // free-slot search and remainder launch
    assign scan_free = !slot_valid_reg[scan_idx_reg];
    assign mod_start = (state_reg == S_HOLD_SCAN) && scan_free && (jit_eff != '0);

    tdst_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rng_next),
        .divisor  (span),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // slot memories
    assign slot_we   = (state_reg == S_HOLD_WRITE);
    assign due_wdata = {1'b0, req_now_reg} + tdst_pkg::DUE_W'(delay_reg);

    tdst_ram #(
        .WIDTH (tdst_pkg::DUE_W),
        .DEPTH (tdst_pkg::SLOT_COUNT)
    ) u_due_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (free_idx_reg),
        .wdata (due_wdata),
        .raddr (scan_idx_reg),
        .rdata (due_rdata)
    );

    tdst_ram #(
        .WIDTH ($bits(tdst_pkg::desc_t)),
        .DEPTH (tdst_pkg::SLOT_COUNT)
    ) u_desc_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (free_idx_reg),
        .wdata (req_desc_reg),
        .raddr (best_idx_next),
        .rdata (desc_rdata)
    );

    // earliest due slot, strict compare keeps the lowest index on ties
    assign cand_hit = cmp_pend_reg && cand_valid_reg
                   && (due_rdata <= {1'b0, req_now_reg})
                   && (!best_found_reg || (due_rdata < best_due_reg));
    assign best_found_next = best_found_reg || cand_hit;
    assign best_idx_next   = cand_hit ? cand_idx_reg : best_idx_reg;

    // sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            latency_reg    <= '0;
            jitter_reg     <= '0;
            rng_reg        <= tdst_pkg::SEED_DEFAULT;
            slot_valid_reg <= '0;
            cmp_pend_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            occ_reg        <= '0;
            peak_reg       <= '0;
            refused_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    tdst_pkg::CFG_LATENCY: latency_reg <= cfg_data[tdst_pkg::CFG_W-1:0];
                    tdst_pkg::CFG_JITTER:  jitter_reg  <= cfg_data[tdst_pkg::CFG_W-1:0];
                    tdst_pkg::CFG_SEED:
                    begin
                        if (cfg_data == '0)
                        begin
                            rng_reg <= tdst_pkg::SEED_DEFAULT;
                        end
                        else
                        begin
                            rng_reg <= cfg_data[tdst_pkg::RAND_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end

            // result taken and no new one loaded in its place
            if (out_xfer && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        req_now_reg  <= now_ms;
                        req_desc_reg <= '{tag: buffer_tag, len: length,
                                          addr: src_addr, port: src_port};
                        req_cap_reg  <= capacity;
                        res_desc_reg <= '0;
                        scan_idx_reg <= '0;
                        if (req_type == tdst_pkg::REQ_HOLD)
                        begin
                            if (!hold_ok)
                            begin
                                res_status_reg <= tdst_pkg::STAT_REJECTED;
                                state_reg      <= S_FINISH;
                            end
                            else if (table_full)
                            begin
                                if (refused_reg != '1)
                                begin
                                    refused_reg <= refused_reg + 1'b1;
                                end
                                res_status_reg <= tdst_pkg::STAT_FULL;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_HOLD_SCAN;
                            end
                        end
                        else
                        begin
                            best_found_reg <= 1'b0;
                            cmp_pend_reg   <= 1'b0;
                            if (capacity == '0)
                            begin
                                res_status_reg <= tdst_pkg::STAT_NOTHING;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_POLL_SCAN;
                            end
                        end
                    end
                end

                S_HOLD_SCAN:
                begin
                    if (scan_free)
                    begin
                        free_idx_reg <= scan_idx_reg;
                        if (jit_eff != '0)
                        begin
                            rng_reg   <= rng_next;
                            state_reg <= S_HOLD_MOD;
                        end
                        else
                        begin
                            delay_reg <= tdst_pkg::DELAY_W'(latency_reg);
                            state_reg <= S_HOLD_WRITE;
                        end
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                S_HOLD_MOD:
                begin
                    if (mod_done)
                    begin
                        delay_reg <= tdst_pkg::DELAY_W'(latency_reg)
                                   + tdst_pkg::DELAY_W'(mod_rem)
                                   - tdst_pkg::DELAY_W'(jit_eff);
                        state_reg <= S_HOLD_WRITE;
                    end
                end

                S_HOLD_WRITE:
                begin
                    slot_valid_reg[free_idx_reg] <= 1'b1;
                    occ_reg <= occ_inc;
                    if (occ_inc > peak_reg)
                    begin
                        peak_reg <= occ_inc;
                    end
                    res_status_reg <= tdst_pkg::STAT_HELD;
                    state_reg      <= S_FINISH;
                end

                S_POLL_SCAN:
                begin
                    cmp_pend_reg   <= 1'b1;
                    cand_valid_reg <= slot_valid_reg[scan_idx_reg];
                    cand_idx_reg   <= scan_idx_reg;
                    best_found_reg <= best_found_next;
                    best_idx_reg   <= best_idx_next;
                    if (cand_hit)
                    begin
                        best_due_reg <= due_rdata;
                    end
                    if (scan_idx_reg == tdst_pkg::SLOT_W'(tdst_pkg::SLOT_COUNT - 1))
                    begin
                        state_reg <= S_POLL_LAST;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                S_POLL_LAST:
                begin
                    cmp_pend_reg   <= 1'b0;
                    best_found_reg <= best_found_next;
                    best_idx_reg   <= best_idx_next;
                    if (best_found_next)
                    begin
                        state_reg <= S_POLL_READ;
                    end
                    else
                    begin
                        res_status_reg <= tdst_pkg::STAT_NOTHING;
                        state_reg      <= S_FINISH;
                    end
                end

                S_POLL_READ:
                begin
                    res_desc_reg <= desc_rdata;
                    if (desc_rdata.len > req_cap_reg)
                    begin
                        res_status_reg <= tdst_pkg::STAT_DROPPED;
                    end
                    else
                    begin
                        res_status_reg <= tdst_pkg::STAT_DELIVERED;
                    end
                    slot_valid_reg[best_idx_reg] <= 1'b0;
                    if (occ_reg != '0)
                    begin
                        occ_reg <= occ_reg - 1'b1;
                    end
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= res_status_reg;
                        out_desc_reg    <= res_desc_reg;
                        out_live_reg    <= occ_reg[tdst_pkg::LIVE_W-1:0];
                        out_peak_reg    <= peak_reg[tdst_pkg::LIVE_W-1:0];
                        out_refused_reg <= refused_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign out_tag        = out_desc_reg.tag;
    assign out_length     = out_desc_reg.len;
    assign out_src_addr   = out_desc_reg.addr;
    assign out_src_port   = out_desc_reg.port;
    assign live_count     = out_live_reg;
    assign peak_count     = out_peak_reg;
    assign overflow_count = out_refused_reg;

    assign res_is_slot = (out_status_reg == tdst_pkg::STAT_DELIVERED)
                      || (out_status_reg == tdst_pkg::STAT_DROPPED);

`ifndef SYNTHESIS
    // occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == tdst_pkg::OCC_W'($countones(slot_valid_reg)))
        else $error("occupancy differs from number of valid slots");

    // peak never below current occupancy
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= occ_reg)
        else $error("peak below occupancy");

    // a hold never overwrites a live slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD_WRITE) |-> !slot_valid_reg[free_idx_reg])
        else $error("hold writes an occupied slot");

    // descriptor fields are zero unless a slot was freed
    a_desc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_is_slot) |-> (out_desc_reg == '0))
        else $error("descriptor reported without a freed slot");
`endif

endmodule

@@ dv/timed_delay_slot_table_test.sv @@
// Self-checking testbench of timed_delay_slot_table: directed rows, then random traffic.
// Results are checked against a slot-table predictor kept in this file, or against fixed results in typed rows.
// Depends on tdst_pkg and the timed_delay_slot_table RTL.
module timed_delay_slot_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tdst_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    // one request transfer
    typedef struct packed {
        logic              req;
        logic [TIME_W-1:0] now;
        desc_t             d;
        logic [CAP_W-1:0]  cap;
    } request_t;

    // one result transfer
    typedef struct packed {
        status_t            st;
        desc_t              d;
        logic [LIVE_W-1:0]  live;
        logic [LIVE_W-1:0]  peak;
        logic [COUNT_W-1:0] ovf;
    } result_t;

    typedef enum logic { ROW_WRITE, ROW_SEND } row_kind_t;

    // one row of the directed plan
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        request_t              rq;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = 1'b0;
    logic [TIME_W-1:0]      now_ms = '0;
    logic [TAG_W-1:0]       buffer_tag = '0;
    logic [LEN_W-1:0]       length = '0;
    logic [ADDR_W-1:0]      src_addr = '0;
    logic [PORT_W-1:0]      src_port = '0;
    logic [CAP_W-1:0]       capacity = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [TAG_W-1:0]       out_tag;
    logic [LEN_W-1:0]       out_length;
    logic [ADDR_W-1:0]      out_src_addr;
    logic [PORT_W-1:0]      out_src_port;
    logic [LIVE_W-1:0]      live_count;
    logic [LIVE_W-1:0]      peak_count;
    logic [COUNT_W-1:0]     overflow_count;

    // shadow copy of the slot table and its registers
    bit                   slot_busy [SLOT_COUNT];
    logic [DUE_W-1:0]     slot_due_ms [SLOT_COUNT];
    desc_t                slot_desc [SLOT_COUNT];
    logic [CFG_W-1:0]     shadow_latency = '0;
    logic [CFG_W-1:0]     shadow_jitter = '0;
    logic [RAND_W-1:0]    rng_word = SEED_DEFAULT;
    logic [LIVE_W-1:0]    live_slots = '0;
    logic [LIVE_W-1:0]    live_high = '0;
    logic [COUNT_W-1:0]   refused_holds = '0;

    result_t   pending_results [$];
    plan_row_t plan [$];
    int        errors = 0;
    int        cycles = 0;
    int        items_sent = 0;
    int        writes_done = 0;
    int        status_seen [8];
    int        idle_odds = 4;
    bit        calm = 1'b0;
    logic [TIME_W-1:0] traffic_clock = '0;

    timed_delay_slot_table uut (.*);

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stall bursts
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_stall = 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if ($urandom_range(idle_odds - 1) == 0)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(0, 16);
        end
        else
            out_stall = 1'b0;
    end

    function automatic void compare_field(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t oldest;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result transfer with nothing expected, expected none actual status %0d",
                         $time, status);
            end
            else
            begin
                oldest = pending_results.pop_front();
                compare_field("status", 64'(oldest.st), 64'(status));
                compare_field("out_tag", 64'(oldest.d.tag), 64'(out_tag));
                compare_field("out_length", 64'(oldest.d.len), 64'(out_length));
                compare_field("out_src_addr", 64'(oldest.d.addr), 64'(out_src_addr));
                compare_field("out_src_port", 64'(oldest.d.port), 64'(out_src_port));
                compare_field("live_count", 64'(oldest.live), 64'(live_count));
                compare_field("peak_count", 64'(oldest.peak), 64'(peak_count));
                compare_field("overflow_count", 64'(oldest.ovf), 64'(overflow_count));
                status_seen[status]++;
            end
        end
    end

    // slot table predictor: updates the shadow state and returns the result
    function automatic result_t predict_slot_result(input request_t r);
        result_t           res;
        int unsigned       pick;
        int unsigned       jit;
        logic [RAND_W-1:0] x;
        logic [DUE_W-1:0]  delay;
        res = '0;
        pick = SLOT_COUNT;
        if (r.req == REQ_HOLD)
        begin
            if (shadow_latency == 0 || shadow_latency > LATENCY_CEILING ||
                r.d.len == 0 || r.d.len > MAX_DATAGRAM)
                res.st = STAT_REJECTED;
            else
            begin
                // lowest free slot
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                    if (!slot_busy[i])
                        pick = i;
                if (pick == SLOT_COUNT)
                begin
                    if (refused_holds != '1)
                        refused_holds++;
                    res.st = STAT_FULL;
                end
                else
                begin
                    jit = 32'((shadow_jitter > shadow_latency) ? shadow_latency : shadow_jitter);
                    delay = DUE_W'(shadow_latency);
                    if (jit != 0)
                    begin
                        x = rng_word;
                        x = x ^ (x << XS_A);
                        x = x ^ (x >> XS_B);
                        x = x ^ (x << XS_C);
                        rng_word = x;
                        delay = delay + DUE_W'(x % (2 * jit + 1)) - DUE_W'(jit);
                    end
                    slot_busy[pick] = 1'b1;
                    slot_due_ms[pick] = {1'b0, r.now} + delay;
                    slot_desc[pick] = r.d;
                    live_slots++;
                    if (live_slots > live_high)
                        live_high = live_slots;
                    res.st = STAT_HELD;
                end
            end
        end
        else
        begin
            res.st = STAT_NOTHING;
            // earliest due slot, lowest index on ties
            if (r.cap != 0)
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (slot_busy[i] && slot_due_ms[i] <= {1'b0, r.now})
                        if (pick == SLOT_COUNT || slot_due_ms[i] < slot_due_ms[pick])
                            pick = i;
            if (pick != SLOT_COUNT)
            begin
                res.st = (slot_desc[pick].len > r.cap) ? STAT_DROPPED : STAT_DELIVERED;
                res.d = slot_desc[pick];
                slot_busy[pick] = 1'b0;
                live_slots--;
            end
        end
        res.live = live_slots;
        res.peak = live_high;
        res.ovf = refused_holds;
        return res;
    endfunction

    // drop valid and wait until every result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        writes_done++;
        case (idx)
            CFG_LATENCY: shadow_latency = val[CFG_W-1:0];
            CFG_JITTER:  shadow_jitter = val[CFG_W-1:0];
            CFG_SEED:
            begin
                rng_word = (val == 0) ? SEED_DEFAULT : val;
            end
            default: ;
        endcase
    endtask

    // random sender gap before a transfer
    task automatic sender_gap();
        if (!calm && $urandom_range(idle_odds - 1) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    // one request transfer; valid stays high for a following transfer
    task automatic send_request(input request_t r, input bit typed, input result_t want);
        result_t predicted;
        @(negedge clk);
        in_valid = 1'b1;
        req_type = r.req;
        now_ms = r.now;
        buffer_tag = r.d.tag;
        length = r.d.len;
        src_addr = r.d.addr;
        src_port = r.d.port;
        capacity = r.cap;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_slot_result(r);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    function automatic request_t mk_req(input logic rq, input logic [TIME_W-1:0] t,
                                        input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [PORT_W-1:0] port,
                                        input logic [CAP_W-1:0] cap);
        request_t r;
        r.req = rq;
        r.now = t;
        r.d.tag = tag;
        r.d.len = len;
        r.d.addr = addr;
        r.d.port = port;
        r.cap = cap;
        return r;
    endfunction

    function automatic result_t mk_res(input status_t st, input desc_t d,
                                       input logic [LIVE_W-1:0] live,
                                       input logic [LIVE_W-1:0] peak,
                                       input logic [COUNT_W-1:0] ovf);
        result_t res;
        res.st = st;
        res.d = d;
        res.live = live;
        res.peak = peak;
        res.ovf = ovf;
        return res;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.val = val;
        row.rq = '0;
        row.typed = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_send(input request_t rq, input bit typed, input result_t want);
        plan_row_t row;
        row.kind = ROW_SEND;
        row.idx = '0;
        row.val = '0;
        row.rq = rq;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    // random request on a mostly rising time line, with some stray times
    function automatic request_t make_traffic_item(input int hold_pct, input int step_max);
        request_t          r;
        logic [31:0]       hi;
        logic [LEN_W-1:0]  len;
        logic [CAP_W-1:0]  cap;
        int                sel;
        traffic_clock = traffic_clock + TIME_W'($urandom_range(0, step_max));
        r.now = traffic_clock;
        if ($urandom_range(19) == 0)
        begin
            hi = $urandom;
            r.now = {hi[15:0], 32'($urandom)};
        end
        sel = $urandom_range(19);
        case (sel)
            0:       len = '0;
            1:       len = LEN_W'($urandom_range(MAX_DATAGRAM + 1, 65535));
            2:       len = LEN_W'(MAX_DATAGRAM);
            3:       len = LEN_W'(1);
            default: len = LEN_W'($urandom_range(1, MAX_DATAGRAM));
        endcase
        sel = $urandom_range(9);
        case (sel)
            0:       cap = '0;
            1:       cap = '1;
            2:       cap = CAP_W'($urandom_range(1, 64));
            3:       cap = CAP_W'($urandom);
            default: cap = CAP_W'($urandom_range(1, 2000));
        endcase
        r.req = ($urandom_range(99) < hold_pct) ? REQ_HOLD : REQ_POLL;
        r.d.tag = TAG_W'($urandom);
        r.d.len = len;
        r.d.addr = $urandom;
        r.d.port = PORT_W'($urandom);
        r.cap = cap;
        return r;
    endfunction

    task automatic run_traffic(input int n, input int hold_pct, input int step_max);
        repeat (n)
        begin
            sender_gap();
            if ($urandom_range(39) == 0)
                wait_drained();
            send_request(make_traffic_item(hold_pct, step_max), 1'b0, '0);
        end
    endtask

    // stimulus
    initial
    begin
        logic [31:0] hi;
        logic [CFG_DATA_W-1:0] word;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed plan: disabled block, length limits, capacity cases, time top, ties
        add_send(mk_req(REQ_HOLD, 0, 1, 100, 32'h0a000001, 53, 0), 1,
                 mk_res(STAT_REJECTED, '0, 0, 0, 0));
        add_send(mk_req(REQ_POLL, 0, 0, 0, 0, 0, 1500), 1, mk_res(STAT_NOTHING, '0, 0, 0, 0));
        add_write(CFG_LATENCY, 2047);
        add_send(mk_req(REQ_HOLD, 1, 2, 100, 0, 0, 0), 1, mk_res(STAT_REJECTED, '0, 0, 0, 0));
        add_write(CFG_LATENCY, 10);
        add_write(CFG_JITTER, 0);
        add_send(mk_req(REQ_HOLD, 2, 3, 0, 0, 0, 0), 1, mk_res(STAT_REJECTED, '0, 0, 0, 0));
        add_send(mk_req(REQ_HOLD, 2, 4, LEN_W'(MAX_DATAGRAM + 1), 0, 0, 0), 1,
                 mk_res(STAT_REJECTED, '0, 0, 0, 0));
        add_send(mk_req(REQ_HOLD, 2, 5, 16'hffff, 0, 0, 0), 1,
                 mk_res(STAT_REJECTED, '0, 0, 0, 0));
        add_send(mk_req(REQ_HOLD, 0, 16'hffff, LEN_W'(MAX_DATAGRAM), 32'hffffffff, 16'hffff, 0),
                 1, mk_res(STAT_HELD, '0, 1, 1, 0));
        add_send(mk_req(REQ_HOLD, 5, 0, 1, 0, 0, 16'hffff), 1, mk_res(STAT_HELD, '0, 2, 2, 0));
        add_send(mk_req(REQ_POLL, 9, 0, 0, 0, 0, 16'hffff), 1, mk_res(STAT_NOTHING, '0, 2, 2, 0));
        add_send(mk_req(REQ_POLL, 20, 0, 0, 0, 0, 0), 1, mk_res(STAT_NOTHING, '0, 2, 2, 0));
        add_send(mk_req(REQ_POLL, 20, 0, 0, 0, 0, CAP_W'(MAX_DATAGRAM - 1)), 1,
                 mk_res(STAT_DROPPED, '{16'hffff, 16'(MAX_DATAGRAM), 32'hffffffff, 16'hffff},
                        1, 2, 0));
        add_send(mk_req(REQ_POLL, 20, 0, 0, 0, 0, 1), 1,
                 mk_res(STAT_DELIVERED, '{16'h0, 16'd1, 32'h0, 16'h0}, 0, 2, 0));
        // due time past the top of the clock never comes due
        add_write(CFG_LATENCY, 1);
        add_send(mk_req(REQ_HOLD, TIME_TOP, 16'h1234, 64, 32'hc0a80001, 8080, 0), 1,
                 mk_res(STAT_HELD, '0, 1, 2, 0));
        add_send(mk_req(REQ_POLL, TIME_TOP, 0, 0, 0, 0, 16'hffff), 1,
                 mk_res(STAT_NOTHING, '0, 1, 2, 0));
        // jitter clamped to latency, default seed by a zero write
        add_write(CFG_JITTER, 2000);
        add_write(CFG_SEED, 0);
        add_send(mk_req(REQ_HOLD, 100, 11, 200, 32'h01020304, 1000, 0), 0, '0);
        add_send(mk_req(REQ_HOLD, 100, 12, 300, 32'h05060708, 2000, 0), 0, '0);
        add_send(mk_req(REQ_POLL, 102, 0, 0, 0, 0, CAP_W'(MAX_DATAGRAM)), 0, '0);
        add_send(mk_req(REQ_POLL, 102, 0, 0, 0, 0, CAP_W'(MAX_DATAGRAM)), 0, '0);
        // latency at the ceiling with jitter just below it
        add_write(CFG_SEED, 32'hffffffff);
        add_write(CFG_LATENCY, LATENCY_CEILING);
        add_write(CFG_JITTER, 1999);
        add_send(mk_req(REQ_HOLD, 1000, 13, 700, 32'h7f000001, 443, 0), 0, '0);
        add_send(mk_req(REQ_POLL, 5000, 0, 0, 0, 0, 16'hffff), 0, '0);
        // equal due times go out in slot order
        add_write(CFG_JITTER, 0);
        add_write(CFG_LATENCY, 3);
        add_send(mk_req(REQ_HOLD, 50, 21, 10, 32'h0a0a0a0a, 21, 0), 0, '0);
        add_send(mk_req(REQ_HOLD, 50, 22, 20, 32'h0b0b0b0b, 22, 0), 0, '0);
        add_send(mk_req(REQ_POLL, 60, 0, 0, 0, 0, CAP_W'(MAX_DATAGRAM)), 0, '0);
        add_send(mk_req(REQ_POLL, 60, 0, 0, 0, 0, CAP_W'(MAX_DATAGRAM)), 0, '0);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
                write_reg(plan[k].idx, plan[k].val);
            else
            begin
                sender_gap();
                send_request(plan[k].rq, plan[k].typed, plan[k].want);
            end
        end

        // shortest latency, no jitter
        hi = $urandom;
        traffic_clock = {hi[14:0], 1'b0, 32'($urandom)};
        idle_odds = 3;
        write_reg(CFG_LATENCY, 1);
        write_reg(CFG_JITTER, 0);
        write_reg(CFG_SEED, $urandom);
        run_traffic(50, 55, 3);

        // random latency and jitter, jitter often above latency
        idle_odds = 8;
        word = $urandom;
        word[CFG_W-1:0] = CFG_W'($urandom_range(2, 200));
        write_reg(CFG_LATENCY, word);
        word = $urandom;
        word[CFG_W-1:0] = CFG_W'($urandom_range(0, 300));
        write_reg(CFG_JITTER, word);
        write_reg(CFG_SEED, $urandom);
        run_traffic(60, 50, 40);

        // fill the table until holds are refused
        idle_odds = 20;
        write_reg(CFG_LATENCY, LATENCY_CEILING);
        write_reg(CFG_JITTER, LATENCY_CEILING);
        write_reg(CFG_SEED, 0);
        while (live_slots != SLOT_COUNT)
        begin
            sender_gap();
            send_request(make_traffic_item(100, 0), 1'b0, '0);
        end
        repeat (6)
        begin
            sender_gap();
            send_request(mk_req(REQ_HOLD, traffic_clock, TAG_W'($urandom),
                                LEN_W'($urandom_range(1, MAX_DATAGRAM)),
                                $urandom, PORT_W'($urandom), 0), 1'b0, '0);
        end

        // drain and refill once everything is due
        idle_odds = 5;
        traffic_clock = traffic_clock + TIME_W'(2 * LATENCY_CEILING + 100);
        run_traffic(40, 40, 50);

        // steady traffic with no idling on either side
        write_reg(CFG_LATENCY, 700);
        write_reg(CFG_JITTER, 5);
        calm = 1'b1;
        run_traffic(50, 45, 300);

        wait_drained();
        repeat (SLOT_COUNT + 40) @(posedge clk);
        $display("run covered %0d request transfers and %0d register writes, peak occupancy %0d",
                 items_sent, writes_done, live_high);
        $display("held %0d, full %0d, rejected %0d, delivered %0d, nothing due %0d, dropped %0d",
                 status_seen[STAT_HELD], status_seen[STAT_FULL], status_seen[STAT_REJECTED],
                 status_seen[STAT_DELIVERED], status_seen[STAT_NOTHING],
                 status_seen[STAT_DROPPED]);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ timed_delay_slot_table.f @@
sv/tdst_pkg.sv
sv/tdst_ram.sv
sv/tdst_mod.sv
sv/timed_delay_slot_table.sv
dv/timed_delay_slot_table_test.sv
